>>> src/fvn_pkg.sv
package fvn_pkg;

    localparam int OCTAVES        = 4;
    localparam int FRAC_BITS      = 16;
    localparam int COS_TABLE_BITS = 10;
    localparam int HEIGHT_BITS    = 18;

    localparam int COS_ENTRIES = 1 << COS_TABLE_BITS;
    localparam int SIN_TERMS   = 8;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // lattice hash constants
    localparam logic [31:0] HASH_ZMUL  = 32'd57;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] HASH_MUL_A = 32'd60493;
    localparam logic [31:0] HASH_ADD_A = 32'd19990303;
    localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;

    // corner / blend value width, product width, running sum width
    localparam int CW    = FRAC_BITS + 2;
    localparam int PW    = 2 * CW;
    localparam int ACC_W = FRAC_BITS + 6;
    localparam int SH_W  = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;

    typedef logic signed [31:0]          t_coord;
    typedef logic signed [ACC_W-1:0]     t_acc;
    typedef logic [SH_W-1:0]             t_sh;
    typedef logic [FRAC_BITS:0]          t_wgt;
    typedef logic [COS_TABLE_BITS-1:0]   t_idx;
    typedef t_wgt                        t_cos_rom [COS_ENTRIES];

    // what one cell hands to its neighbor
    typedef struct packed {
        logic   vld;
        t_coord cx;
        t_coord cz;
        t_acc   acc;
        t_sh    sh;
    } t_link;

    // unsigned floor quotient by shift and subtract, table build only
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // (1 - cos(pi*k/N)) / 2 as sin^2(pi*k/2N), taylor series in q30
    function automatic t_cos_rom build_cos_rom();
        t_cos_rom        rom;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned s;
        longint unsigned t;
        int              k;
        int              m;
        for (k = 0; k < COS_ENTRIES; k++) begin
            u  = (PI_Q30 * 64'(k)) >> (COS_TABLE_BITS + 1);
            u2 = (u * u) >> 30;
            s  = u;
            t  = u;
            for (m = 1; m <= SIN_TERMS; m++) begin
                t = div_u64((t * u2) >> 30, 64'(2 * m) * 64'(2 * m + 1));
                if (m[0] == 1'b1) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
            end
            rom[k] = t_wgt'((s * s + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
        end
        return rom;
    endfunction

endpackage

>>> src/fvn_cell.sv
module fvn_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fvn_pkg::t_link i_lnk,
    output fvn_pkg::t_link o_lnk
);
    import fvn_pkg::*;

    localparam t_cos_rom COS_ROM = build_cos_rom();
    localparam logic signed [CW-1:0] ONE = CW'(1 << FRAC_BITS);

    function automatic t_idx rom_index(input t_coord c);
        logic [FRAC_BITS+COS_TABLE_BITS-1:0] ext;
        ext = {c[FRAC_BITS-1:0], {COS_TABLE_BITS{1'b0}}};
        return ext[FRAC_BITS+COS_TABLE_BITS-1 -: COS_TABLE_BITS];
    endfunction

    function automatic logic [31:0] lattice_mix(input logic [31:0] ix, input logic [31:0] iz);
        logic [31:0] n;
        n = ix + iz * HASH_ZMUL;
        return (n << HASH_SHIFT) ^ n;
    endfunction

    function automatic logic signed [CW-1:0] corner_val(input logic [31:0] h);
        logic signed [32:0] d;
        d = 33'sd1073741824 - $signed({2'b00, h[30:0]});
        return CW'(d >>> (30 - FRAC_BITS));
    endfunction

    // link carried alongside each stage: a..g
    t_link r_lnk [7];

    // stage a: mixed lattice keys and weights
    logic [31:0] r_na [4];
    t_wgt        r_wx_a, r_wz_a;
    // stage b: squares
    logic [31:0] r_nb [4];
    logic [31:0] r_sq [4];
    t_wgt        r_wx_b, r_wz_b;
    // stage c
    logic [31:0] r_nc [4];
    logic [31:0] r_m2 [4];
    t_wgt        r_wx_c, r_wz_c;
    // stage d: hashes
    logic [31:0] r_h [4];
    t_wgt        r_wx_d, r_wz_d;
    // stage e: x blend products
    logic signed [PW-1:0] r_p [4];
    t_wgt                 r_wz_e;
    // stage f: x blend results
    logic signed [CW-1:0] r_i1, r_i2;
    t_wgt                 r_wz_f;
    // stage g: z blend products
    logic signed [PW-1:0] r_q0, r_q1;
    // stage h: output link
    t_link r_out;

    logic [31:0] ix, iz, ix1, iz1;
    logic [31:0] n_na [4];
    logic signed [CW-1:0] wx_s, wz_s, omx, omz;
    logic signed [PW:0]   sum0, sum1, sumq;
    logic signed [CW-1:0] oct, contrib;
    t_link                n_out;

    always_comb begin
        ix  = 32'(i_lnk.cx >>> FRAC_BITS);
        iz  = 32'(i_lnk.cz >>> FRAC_BITS);
        ix1 = ix + 32'd1;
        iz1 = iz + 32'd1;
        n_na[0] = lattice_mix(ix,  iz);
        n_na[1] = lattice_mix(ix1, iz);
        n_na[2] = lattice_mix(ix,  iz1);
        n_na[3] = lattice_mix(ix1, iz1);

        wx_s = $signed({1'b0, r_wx_d});
        omx  = ONE - wx_s;
        wz_s = $signed({1'b0, r_wz_f});
        omz  = ONE - wz_s;

        sum0 = (PW+1)'(r_p[0]) + (PW+1)'(r_p[1]);
        sum1 = (PW+1)'(r_p[2]) + (PW+1)'(r_p[3]);
        sumq = (PW+1)'(r_q0) + (PW+1)'(r_q1);
        oct     = CW'(sumq >>> FRAC_BITS);
        contrib = oct >>> r_lnk[6].sh;

        n_out     = r_lnk[6];
        n_out.acc = r_lnk[6].acc + ACC_W'(contrib);
        n_out.cx  = r_lnk[6].cx <<< 1;
        n_out.cz  = r_lnk[6].cz <<< 1;
        n_out.sh  = r_lnk[6].sh + SH_W'(1);
    end

    // rom reads, registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx_a <= COS_ROM[rom_index(i_lnk.cx)];
            r_wz_a <= COS_ROM[rom_index(i_lnk.cz)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 7; j++) begin
                r_lnk[j].vld <= 1'b0;
            end
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_lnk[0] <= i_lnk;
            for (int j = 1; j < 7; j++) begin
                r_lnk[j] <= r_lnk[j-1];
            end
            r_out <= n_out;
        end
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_na[c] <= n_na[c];
                r_nb[c] <= r_na[c];
                r_sq[c] <= r_na[c] * r_na[c];
                r_nc[c] <= r_nb[c];
                r_m2[c] <= r_sq[c] * HASH_MUL_A + HASH_ADD_A;
                r_h[c]  <= (r_nc[c] * r_m2[c] + HASH_ADD_B) & HASH_MASK;
            end
            r_wx_b <= r_wx_a;  r_wz_b <= r_wz_a;
            r_wx_c <= r_wx_b;  r_wz_c <= r_wz_b;
            r_wx_d <= r_wx_c;  r_wz_d <= r_wz_c;
            r_p[0] <= corner_val(r_h[0]) * omx;
            r_p[1] <= corner_val(r_h[1]) * wx_s;
            r_p[2] <= corner_val(r_h[2]) * omx;
            r_p[3] <= corner_val(r_h[3]) * wx_s;
            r_wz_e <= r_wz_d;
            r_i1   <= CW'(sum0 >>> FRAC_BITS);
            r_i2   <= CW'(sum1 >>> FRAC_BITS);
            r_wz_f <= r_wz_e;
            r_q0   <= r_i1 * omz;
            r_q1   <= r_i2 * wz_s;
        end
    end

    assign o_lnk = r_out;

endmodule

>>> src/fractal_value_noise_top.sv
// channel | valid    | stall    | payload
// request | i_valid  | o_stall  | i_coord_x, i_coord_z (signed q16.16)
// result  | o_valid  | i_stall  | o_height (signed q2.16)
//
// one request per clock sustained while the output is not stalled; the octave
// cells run as a chain, followed by one output register
// each cell is an 8-stage pipe: lattice mix and rom read, three hash multiplies,
// x blend products, x blend sum, z blend products, z blend sum and accumulate
// synchronous active-low reset clears only the valid bits
// the whole chain holds while a result sits in the output register and is stalled
module fractal_value_noise_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [31:0]                 i_coord_x,
    input  logic signed [31:0]                 i_coord_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [fvn_pkg::HEIGHT_BITS-1:0] o_height
);
    import fvn_pkg::*;

    localparam int CMP_W = ACC_W + HEIGHT_BITS;
    localparam logic signed [CMP_W-1:0] H_MAX = CMP_W'((1 << (HEIGHT_BITS - 1)) - 1);
    localparam logic signed [CMP_W-1:0] H_MIN = -CMP_W'(1 << (HEIGHT_BITS - 1));

    // the whole pipe advances together unless the output is held
    logic w_en;
    t_link w_lnk [OCTAVES+1];

    logic                          r_out_vld;
    logic signed [HEIGHT_BITS-1:0] r_height;
    logic signed [HEIGHT_BITS-1:0] n_height;
    logic signed [CMP_W-1:0]       w_tot;

    assign w_en = !(r_out_vld && i_stall);

    // request enters the first cell with an empty sum at octave zero
    always_comb begin
        w_lnk[0].vld = i_valid;
        w_lnk[0].cx  = i_coord_x;
        w_lnk[0].cz  = i_coord_z;
        w_lnk[0].acc = '0;
        w_lnk[0].sh  = '0;
    end

    // one cell per octave; each doubles the coordinates for its neighbor
    for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
        fvn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_lnk   (w_lnk[g]),
            .o_lnk   (w_lnk[g+1])
        );
    end

    // saturate the sum to the output range
    always_comb begin
        w_tot = CMP_W'(w_lnk[OCTAVES].acc);
        if (w_tot > H_MAX) begin
            n_height = HEIGHT_BITS'(H_MAX);
        end else if (w_tot < H_MIN) begin
            n_height = HEIGHT_BITS'(H_MIN);
        end else begin
            n_height = HEIGHT_BITS'(w_tot);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_lnk[OCTAVES].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_height <= n_height;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_height = r_height;
    assign o_stall  = !w_en;

    // output empty right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // the chain is frozen while the output is held
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && $past(i_rst_n)) |=> $stable(w_lnk[OCTAVES]))
        else $error("cell chain moved while output held");

    // four octaves at q16 stay within 1.875
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && FRAC_BITS == 16 && OCTAVES == 4) |->
        (o_height >= -18'sd122880 && o_height <= 18'sd122880))
        else $error("height out of range");

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fvn_pkg::*;

    localparam int HMAX = (1 << (HEIGHT_BITS - 1)) - 1;
    localparam int HMIN = -(1 << (HEIGHT_BITS - 1));
    localparam int PIPE_LAT = 8 * OCTAVES + 1;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic signed [31:0]            i_coord_x;
    logic signed [31:0]            i_coord_z;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [HEIGHT_BITS-1:0] o_height;

    fractal_value_noise_top u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_coord_x (i_coord_x),
        .i_coord_z (i_coord_z),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_height  (o_height)
    );

    // cosine weight table, built independently of the package function
    longint unsigned blend_wgt [COS_ENTRIES];

    // heights still owed by the block, oldest first
    logic signed [HEIGHT_BITS-1:0] height_q [$];

    int mismatch_cnt;
    int send_idle_pct;
    int recv_stall_pct;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // sin^2(pi*k/2N) through a nine-term taylor series in q30
    task automatic fill_wgt_table();
        longint unsigned u;
        longint unsigned u2;
        longint unsigned s;
        longint unsigned t;
        for (int k = 0; k < COS_ENTRIES; k++) begin
            u  = (PI_Q30 * 64'(k)) / (64'(COS_ENTRIES) * 64'd2);
            u2 = (u * u) >> 30;
            s  = u;
            t  = u;
            for (int m = 1; m <= SIN_TERMS; m++) begin
                t = ((t * u2) >> 30) / (64'(2 * m) * 64'(2 * m + 1));
                if (m % 2 == 1) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
            end
            blend_wgt[k] = (s * s + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        end
    endtask

    // lattice corner value (2^30 - hash) floored to FRAC_BITS
    function automatic longint lattice_val(logic [31:0] ix, logic [31:0] iz);
        logic [31:0] n;
        logic [31:0] h;
        n = ix + iz * 32'd57;
        n = (n << 13) ^ n;
        h = (n * (n * n * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fff_ffff;
        return ((longint'(1) << 30) - longint'({32'd0, h})) >>> (30 - FRAC_BITS);
    endfunction

    function automatic longint lerp_cos(longint a, longint b, longint w);
        return (a * ((longint'(1) << FRAC_BITS) - w) + b * w) >>> FRAC_BITS;
    endfunction

    function automatic longint wgt_of(logic [31:0] c);
        logic [31:0] f;
        logic [31:0] idx;
        f = c & ((32'd1 << FRAC_BITS) - 1);
        if (FRAC_BITS >= COS_TABLE_BITS) begin
            idx = f >> (FRAC_BITS - COS_TABLE_BITS);
        end else begin
            idx = f << (COS_TABLE_BITS - FRAC_BITS);
        end
        return longint'(blend_wgt[idx & (COS_ENTRIES - 1)]);
    endfunction

    function automatic longint octave_val(logic [31:0] cx, logic [31:0] cz);
        logic [31:0] ix;
        logic [31:0] iz;
        longint      wx;
        longint      wz;
        longint      r1;
        longint      r2;
        ix = 32'(longint'($signed(cx)) >>> FRAC_BITS);
        iz = 32'(longint'($signed(cz)) >>> FRAC_BITS);
        wx = wgt_of(cx);
        wz = wgt_of(cz);
        r1 = lerp_cos(lattice_val(ix, iz), lattice_val(ix + 1, iz), wx);
        r2 = lerp_cos(lattice_val(ix, iz + 1), lattice_val(ix + 1, iz + 1), wx);
        return lerp_cos(r1, r2, wz);
    endfunction

    function automatic logic signed [HEIGHT_BITS-1:0] noise_height(logic [31:0] x,
                                                                    logic [31:0] z);
        longint sum;
        sum = 0;
        for (int i = 0; i < OCTAVES; i++) begin
            sum += octave_val(x << i, z << i) >>> i;
        end
        if (sum > HMAX) sum = HMAX;
        if (sum < HMIN) sum = HMIN;
        return HEIGHT_BITS'(sum);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_cnt++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // one request; idles first at the sender's rate, then waits for acceptance
    task automatic send_point(logic [31:0] x, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_coord_x <= x;
        i_coord_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        height_q.push_back(noise_height(x, z));
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (height_q.size() == 0) begin
                report_mismatch($sformatf("unexpected height %0d", o_height));
            end else begin
                if (o_height !== height_q[0]) begin
                    report_mismatch($sformatf("height got %0d want %0d",
                                              o_height, height_q[0]));
                end
                void'(height_q.pop_front());
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // extremes, lattice boundaries and wrap of the octave shift
    task automatic test_directed();
        logic [31:0] pts [12];
        pts = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h0000_ffff, 32'h0001_0000, 32'hffff_0000, 32'h4000_0000,
                32'h2000_8000, 32'h7fff_0000, 32'hc000_0001, 32'h0000_8000};
        for (int i = 0; i < 12; i++) begin
            send_point(pts[i], pts[11 - i]);
        end
        send_point(32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h5555_5555, 32'haaaa_aaaa);
        send_point(32'haaaa_aaaa, 32'h5555_5555);
        go_idle();
    endtask

    // sender holds off until the pipe drains
    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++) send_point($urandom, $urandom);
        go_idle();
        while (height_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 10; i++) send_point($urandom, $urandom);
        go_idle();
    endtask

    // random points: mostly small magnitudes, some full range
    task automatic test_random(int count);
        logic [31:0] x;
        logic [31:0] z;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) begin
                x = $urandom;
                z = $urandom;
            end else begin
                x = 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
                z = 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
            end
            send_point(x, z);
        end
        go_idle();
    endtask

    // run limit
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_coord_x      = '0;
        i_coord_z      = '0;
        mismatch_cnt   = 0;
        send_idle_pct  = 19;
        recv_stall_pct = 59;
        fill_wgt_table();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_pause();
        test_random(360);
        send_idle_pct  = 59;
        recv_stall_pct = 19;
        test_random(360);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(380);

        while (height_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
